// ===== hw/rtl/quaternion_vector_rotate_unit_macros.svh =====
// Assertion macros shared by the rotation unit's modules.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define QVR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define QVR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/qvr_pkg.sv =====
package qvr_pkg;

   localparam int COMP_WIDTH  = 16;
   localparam int PROD_WIDTH  = 2 * COMP_WIDTH;
   localparam int MAT_WIDTH   = 2 * COMP_WIDTH + 2;
   localparam int NORM_WIDTH  = 2 * COMP_WIDTH + 1;
   localparam int TERM_WIDTH  = MAT_WIDTH + COMP_WIDTH;
   localparam int NUM_WIDTH   = TERM_WIDTH + 2;
   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [MAT_WIDTH-1:0]  mat_type;
   typedef logic        [NORM_WIDTH-1:0] norm_type;
   typedef logic signed [TERM_WIDTH-1:0] term_type;
   typedef logic signed [NUM_WIDTH-1:0]  num_type;
   typedef logic        [NUM_WIDTH-1:0]  mag_type;

   typedef struct packed {
      comp_type quat_w;
      comp_type quat_x;
      comp_type quat_y;
      comp_type quat_z;
      comp_type vec_x;
      comp_type vec_y;
      comp_type vec_z;
   } req_type;

   typedef struct packed {
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
      logic     zero_norm;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      prod_type ww;
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type xy;
      prod_type wz;
      prod_type xz;
      prod_type wy;
      prod_type yz;
      prod_type wx;
      comp_type vec_x;
      comp_type vec_y;
      comp_type vec_z;
      logic     zero_norm;
   } entry_type;

endpackage

// ===== hw/rtl/qvr_front.sv =====
`include "quaternion_vector_rotate_unit_macros.svh"

module qvr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qvr_pkg::req_type  req_word,
   output logic              push_valid,
   input  logic              push_full,
   output qvr_pkg::entry_type push_word
);

   logic               f_valid_ff;
   logic               f_valid_in;
   qvr_pkg::entry_type f_entry_ff;
   qvr_pkg::entry_type f_entry_in;
   logic               advance;

   assign advance    = !f_valid_ff || !push_full;
   assign req_stall  = !advance;
   assign push_valid = f_valid_ff;
   assign push_word  = f_entry_ff;

   always_comb begin
      f_valid_in = advance ? req_valid : f_valid_ff;
      f_entry_in.ww = req_word.quat_w * req_word.quat_w;
      f_entry_in.xx = req_word.quat_x * req_word.quat_x;
      f_entry_in.yy = req_word.quat_y * req_word.quat_y;
      f_entry_in.zz = req_word.quat_z * req_word.quat_z;
      f_entry_in.xy = req_word.quat_x * req_word.quat_y;
      f_entry_in.wz = req_word.quat_w * req_word.quat_z;
      f_entry_in.xz = req_word.quat_x * req_word.quat_z;
      f_entry_in.wy = req_word.quat_w * req_word.quat_y;
      f_entry_in.yz = req_word.quat_y * req_word.quat_z;
      f_entry_in.wx = req_word.quat_w * req_word.quat_x;
      f_entry_in.vec_x = req_word.vec_x;
      f_entry_in.vec_y = req_word.vec_y;
      f_entry_in.vec_z = req_word.vec_z;
      f_entry_in.zero_norm = (req_word.quat_w == '0) && (req_word.quat_x == '0) &&
                             (req_word.quat_y == '0) && (req_word.quat_z == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (advance) begin
         f_entry_ff <= f_entry_in;
      end
   end

   `QVR_ASSERT_NEXT(a_front_take, clock, reset, req_valid && !req_stall, f_valid_ff, "Accepted word did not reach the front register.")
   `QVR_ASSERT_SAME(a_front_hold, clock, reset, f_valid_ff && push_full, req_stall, "Front accepted a word while the queue was full.")

endmodule

// ===== hw/rtl/qvr_queue.sv =====
`include "quaternion_vector_rotate_unit_macros.svh"

module qvr_queue #(
   parameter int DEPTH = qvr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_full,
   input  qvr_pkg::entry_type push_word,
   output logic               pop_valid,
   input  logic               pop_take,
   output qvr_pkg::entry_type pop_word
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   qvr_pkg::entry_type     slot_ff [0:DEPTH-1];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_full = (count_ff == COUNT_WIDTH'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = slot_ff[rd_ptr_ff];
   assign push      = push_valid && !push_full;
   assign pop       = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   `QVR_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= COUNT_WIDTH'(DEPTH), "Queue count exceeds its depth.")
   `QVR_ASSERT_NEXT(a_queue_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "Queue count did not grow on a push.")

endmodule

// ===== hw/rtl/qvr_back.sv =====
`include "quaternion_vector_rotate_unit_macros.svh"

module qvr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_take,
   input  qvr_pkg::entry_type pop_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qvr_pkg::rsp_type   rsp_word
);

   localparam int W  = qvr_pkg::COMP_WIDTH;
   localparam int MW = qvr_pkg::MAT_WIDTH;
   localparam int NW = qvr_pkg::NUM_WIDTH;
   localparam int DS = qvr_pkg::COMP_WIDTH;

   logic enable;

   logic               b1_valid_ff;
   qvr_pkg::mat_type   b1_m_ff [0:2][0:2];
   qvr_pkg::mat_type   b1_m_in [0:2][0:2];
   qvr_pkg::norm_type  b1_n_ff;
   qvr_pkg::comp_type  b1_v_ff [0:2];
   logic               b1_zero_ff;

   logic               b2_valid_ff;
   qvr_pkg::term_type  b2_p_ff [0:2][0:2];
   qvr_pkg::term_type  b2_p_in [0:2][0:2];
   qvr_pkg::norm_type  b2_n_ff;
   logic               b2_zero_ff;

   logic               b3_valid_ff;
   qvr_pkg::num_type   b3_s_ff [0:2];
   qvr_pkg::num_type   b3_s_in [0:2];
   qvr_pkg::norm_type  b3_n_ff;
   logic               b3_zero_ff;

   logic               d_valid_ff [0:DS];
   qvr_pkg::mag_type   d_rem_ff   [0:DS][0:2];
   qvr_pkg::mag_type   d_rem_in   [0:DS][0:2];
   logic [W-1:0]       d_q_ff     [0:DS][0:2];
   logic [W-1:0]       d_q_in     [0:DS][0:2];
   logic               d_neg_ff   [0:DS][0:2];
   qvr_pkg::norm_type  d_n_ff     [0:DS];
   logic               d_zero_ff  [0:DS];

   logic               rsp_valid_ff;
   qvr_pkg::rsp_type   rsp_word_ff;
   qvr_pkg::rsp_type   rsp_word_in;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign pop_take  = enable;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      b1_m_in[0][0] = MW'(pop_word.ww) + MW'(pop_word.xx) - MW'(pop_word.yy) - MW'(pop_word.zz);
      b1_m_in[1][1] = MW'(pop_word.ww) - MW'(pop_word.xx) + MW'(pop_word.yy) - MW'(pop_word.zz);
      b1_m_in[2][2] = MW'(pop_word.ww) - MW'(pop_word.xx) - MW'(pop_word.yy) + MW'(pop_word.zz);
      b1_m_in[0][1] = (MW'(pop_word.xy) - MW'(pop_word.wz)) <<< 1;
      b1_m_in[0][2] = (MW'(pop_word.xz) + MW'(pop_word.wy)) <<< 1;
      b1_m_in[1][0] = (MW'(pop_word.xy) + MW'(pop_word.wz)) <<< 1;
      b1_m_in[1][2] = (MW'(pop_word.yz) - MW'(pop_word.wx)) <<< 1;
      b1_m_in[2][0] = (MW'(pop_word.xz) - MW'(pop_word.wy)) <<< 1;
      b1_m_in[2][1] = (MW'(pop_word.yz) + MW'(pop_word.wx)) <<< 1;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            b2_p_in[i][j] = b1_m_ff[i][j] * b1_v_ff[j];
         end
         b3_s_in[i] = NW'(b2_p_ff[i][0]) + NW'(b2_p_ff[i][1]) + NW'(b2_p_ff[i][2]);
      end
   end

   always_comb begin
      logic [NW:0] diff;
      for (int c = 0; c < 3; c++) begin
         d_rem_in[0][c] = b3_s_ff[c][NW-1] ? NW'(-b3_s_ff[c]) : NW'(b3_s_ff[c]);
         d_q_in[0][c]   = '0;
      end
      for (int s = 0; s < DS; s++) begin
         for (int c = 0; c < 3; c++) begin
            diff = {1'b0, d_rem_ff[s][c]} - ({1'b0, NW'(d_n_ff[s])} << (W - 1 - s));
            d_q_in[s+1][c] = d_q_ff[s][c];
            if (!diff[NW]) begin
               d_rem_in[s+1][c]         = diff[NW-1:0];
               d_q_in[s+1][c][W-1-s]    = 1'b1;
            end else begin
               d_rem_in[s+1][c] = d_rem_ff[s][c];
            end
         end
      end
   end

   always_comb begin
      logic [W-1:0] lim;
      logic [W-1:0] mag;
      logic [W-1:0] res [0:2];
      logic         sat;
      sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
         lim = d_neg_ff[DS][c] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         mag = d_q_ff[DS][c];
         if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
         end
         res[c] = d_neg_ff[DS][c] ? W'(-mag) : mag;
      end
      if (d_zero_ff[DS]) begin
         rsp_word_in.out_x     = '0;
         rsp_word_in.out_y     = '0;
         rsp_word_in.out_z     = '0;
         rsp_word_in.zero_norm = 1'b1;
         rsp_word_in.saturated = 1'b0;
      end else begin
         rsp_word_in.out_x     = res[0];
         rsp_word_in.out_y     = res[1];
         rsp_word_in.out_z     = res[2];
         rsp_word_in.zero_norm = 1'b0;
         rsp_word_in.saturated = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= DS; s++) begin
            d_valid_ff[s] <= 1'b0;
         end
      end else if (enable) begin
         b1_valid_ff   <= pop_valid;
         b2_valid_ff   <= b1_valid_ff;
         b3_valid_ff   <= b2_valid_ff;
         d_valid_ff[0] <= b3_valid_ff;
         for (int s = 0; s < DS; s++) begin
            d_valid_ff[s+1] <= d_valid_ff[s];
         end
         rsp_valid_ff <= d_valid_ff[DS];
      end
      if (enable) begin
         b1_m_ff    <= b1_m_in;
         b1_n_ff    <= qvr_pkg::NORM_WIDTH'(MW'(pop_word.ww) + MW'(pop_word.xx) +
                                            MW'(pop_word.yy) + MW'(pop_word.zz));
         b1_v_ff[0] <= pop_word.vec_x;
         b1_v_ff[1] <= pop_word.vec_y;
         b1_v_ff[2] <= pop_word.vec_z;
         b1_zero_ff <= pop_word.zero_norm;
         b2_p_ff    <= b2_p_in;
         b2_n_ff    <= b1_n_ff;
         b2_zero_ff <= b1_zero_ff;
         b3_s_ff    <= b3_s_in;
         b3_n_ff    <= b2_n_ff;
         b3_zero_ff <= b2_zero_ff;
         d_n_ff[0]    <= b3_n_ff;
         d_zero_ff[0] <= b3_zero_ff;
         for (int c = 0; c < 3; c++) begin
            d_neg_ff[0][c] <= b3_s_ff[c][NW-1];
         end
         for (int s = 0; s <= DS; s++) begin
            d_rem_ff[s] <= d_rem_in[s];
            d_q_ff[s]   <= d_q_in[s];
         end
         for (int s = 0; s < DS; s++) begin
            d_n_ff[s+1]    <= d_n_ff[s];
            d_zero_ff[s+1] <= d_zero_ff[s];
            d_neg_ff[s+1]  <= d_neg_ff[s];
         end
         rsp_word_ff <= rsp_word_in;
      end
   end

   `QVR_ASSERT_SAME(a_back_zero, clock, reset, rsp_valid_ff && rsp_word_ff.zero_norm, (rsp_word_ff.out_x == '0) && (rsp_word_ff.out_y == '0) && (rsp_word_ff.out_z == '0) && !rsp_word_ff.saturated, "Zero-norm result carries data.")

endmodule

// ===== hw/rtl/quaternion_vector_rotate_unit.sv =====
// Rotates a 3-vector by a quaternion of any length: each word returns the vector part of
// q * (0, v) * conj(q) divided by the squared norm of q, truncated toward zero and saturated
// to 16 bits, with flags for a zero quaternion and for clipping. While the result side does
// not stall, the unit takes one word per cycle and returns one result per cycle. A word goes
// through the front register, queue, matrix, product and sum stages and restoring divider,
// which settles one quotient bit per pipeline stage, into the output register. A small queue
// between the product front end and the divider back end, together with the front register,
// lets the input keep flowing for QUEUE_DEPTH + 1 words while the result side stalls.
module quaternion_vector_rotate_unit #(
   parameter int QUEUE_DEPTH = qvr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qvr_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qvr_pkg::rsp_type rsp_word
);

   logic               push_valid;
   logic               push_full;
   qvr_pkg::entry_type push_word;
   logic               pop_valid;
   logic               pop_take;
   qvr_pkg::entry_type pop_word;

   qvr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_word  (push_word)
   );

   qvr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_word   (pop_word)
   );

   qvr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_take  (pop_take),
      .pop_word  (pop_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
